[rtl/ldr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared widths, register map, reset values and Q2.30 saturation helpers for
// the lens distortion pixel remapper.
// ----------------------------------------------------------------------------
package ldr_pkg;

   localparam int unsigned COORD_W    = 12;
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned FOCAL_W    = 28;
   localparam int unsigned COEF_W     = 32;
   localparam int unsigned ADDR_W     = 5;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned NORM_STEPS = 31;
   localparam int unsigned NORM_LAT   = NORM_STEPS + 2;
   localparam int unsigned DIST_LAT   = 12;

   // register indexes
   localparam logic [2:0] REG_FOCAL_X        = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y        = 3'd1;
   localparam logic [2:0] REG_CENTRE_X       = 3'd2;
   localparam logic [2:0] REG_CENTRE_Y       = 3'd3;
   localparam logic [2:0] REG_RADIAL_ONE     = 3'd4;
   localparam logic [2:0] REG_RADIAL_TWO     = 3'd5;
   localparam logic [2:0] REG_TANGENTIAL_ONE = 3'd6;
   localparam logic [2:0] REG_TANGENTIAL_TWO = 3'd7;

   // reset values
   localparam logic [27:0] RST_FOCAL_X        = 28'd69793805;
   localparam logic [27:0] RST_FOCAL_Y        = 28'd69674563;
   localparam logic [27:0] RST_CENTRE_X       = 28'd62694561;
   localparam logic [27:0] RST_CENTRE_Y       = 28'd34706841;
   localparam logic [31:0] RST_RADIAL_ONE     = 32'sd42749957;
   localparam logic [31:0] RST_RADIAL_TWO     = -32'sd847182;
   localparam logic [31:0] RST_TANGENTIAL_ONE = -32'sd4494683;
   localparam logic [31:0] RST_TANGENTIAL_TWO = 32'sd1183263;

   // build defaults
   localparam int unsigned       DEF_OUT_WIDTH    = 1920;
   localparam int unsigned       DEF_OUT_HEIGHT   = 1080;
   localparam logic signed [31:0] DEF_RADIAL_THREE = -32'sd48211008;

   localparam logic signed [35:0] Q30_ONE = 36'sh040000000;
   localparam logic signed [35:0] WIDE_MAX = 36'sh07FFFFFFF;
   localparam logic signed [35:0] WIDE_MIN = 36'shF80000000;

   typedef struct packed {
      logic [27:0]        focal_x;
      logic [27:0]        focal_y;
      logic [27:0]        centre_x;
      logic [27:0]        centre_y;
      logic signed [31:0] radial_one;
      logic signed [31:0] radial_two;
      logic signed [31:0] tangential_one;
      logic signed [31:0] tangential_two;
   } cfg_type;

   // clamp a wide sum into signed 32 bits
   function automatic logic signed [31:0] sat_wide(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > WIDE_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < WIDE_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q2.30 product: floor shift by 30, then clamp
   function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 30;
      return sat_wide(s[35:0]);
   endfunction

endpackage

[rtl/ldr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_req_if
// Request channel: source pixel coordinates and grey level.
// ----------------------------------------------------------------------------
interface ldr_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] src_column;
   logic [11:0] src_row;
   logic [7:0]  pixel_value;

   modport source (output valid, src_column, src_row, pixel_value, input ready);
   modport sink   (input valid, src_column, src_row, pixel_value, output ready);
endinterface

[rtl/ldr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_rsp_if
// Response channel: destination coordinates, grey level and bounds flag.
// ----------------------------------------------------------------------------
interface ldr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] dest_column;
   logic [11:0] dest_row;
   logic [7:0]  dest_value;
   logic        in_bounds;

   modport source (output valid, dest_column, dest_row, dest_value, in_bounds,
                   input ready);
   modport sink   (input valid, dest_column, dest_row, dest_value, in_bounds,
                   output ready);
endinterface

[rtl/ldr_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_csr
// APB-style register file holding the camera intrinsics and coefficients.
// ----------------------------------------------------------------------------
module ldr_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output ldr_pkg::cfg_type      cfg
);

   ldr_pkg::cfg_type cfg_ff;
   logic [2:0]       idx;

   assign idx    = paddr[4:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x        <= ldr_pkg::RST_FOCAL_X;
         cfg_ff.focal_y        <= ldr_pkg::RST_FOCAL_Y;
         cfg_ff.centre_x       <= ldr_pkg::RST_CENTRE_X;
         cfg_ff.centre_y       <= ldr_pkg::RST_CENTRE_Y;
         cfg_ff.radial_one     <= ldr_pkg::RST_RADIAL_ONE;
         cfg_ff.radial_two     <= ldr_pkg::RST_RADIAL_TWO;
         cfg_ff.tangential_one <= ldr_pkg::RST_TANGENTIAL_ONE;
         cfg_ff.tangential_two <= ldr_pkg::RST_TANGENTIAL_TWO;
      end else if (psel && penable && pwrite) begin
         case (idx)
            ldr_pkg::REG_FOCAL_X:        cfg_ff.focal_x        <= pwdata[27:0];
            ldr_pkg::REG_FOCAL_Y:        cfg_ff.focal_y        <= pwdata[27:0];
            ldr_pkg::REG_CENTRE_X:       cfg_ff.centre_x       <= pwdata[27:0];
            ldr_pkg::REG_CENTRE_Y:       cfg_ff.centre_y       <= pwdata[27:0];
            ldr_pkg::REG_RADIAL_ONE:     cfg_ff.radial_one     <= pwdata;
            ldr_pkg::REG_RADIAL_TWO:     cfg_ff.radial_two     <= pwdata;
            ldr_pkg::REG_TANGENTIAL_ONE: cfg_ff.tangential_one <= pwdata;
            ldr_pkg::REG_TANGENTIAL_TWO: cfg_ff.tangential_two <= pwdata;
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         ldr_pkg::REG_FOCAL_X:        prdata = {4'b0, cfg_ff.focal_x};
         ldr_pkg::REG_FOCAL_Y:        prdata = {4'b0, cfg_ff.focal_y};
         ldr_pkg::REG_CENTRE_X:       prdata = {4'b0, cfg_ff.centre_x};
         ldr_pkg::REG_CENTRE_Y:       prdata = {4'b0, cfg_ff.centre_y};
         ldr_pkg::REG_RADIAL_ONE:     prdata = cfg_ff.radial_one;
         ldr_pkg::REG_RADIAL_TWO:     prdata = cfg_ff.radial_two;
         ldr_pkg::REG_TANGENTIAL_ONE: prdata = cfg_ff.tangential_one;
         ldr_pkg::REG_TANGENTIAL_TWO: prdata = cfg_ff.tangential_two;
         default:                     prdata = 32'd0;
      endcase
   end

endmodule

[rtl/ldr_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_norm
// Pipelined restoring divider: (pos*2^16 - centre) * 2^30 / focal, one
// quotient bit per stage, truncated toward zero and clamped to Q2.30.
// ----------------------------------------------------------------------------
module ldr_norm (
   input  logic                clock,
   input  logic                en,
   input  logic [11:0]         pos,
   input  logic [27:0]         centre,
   input  logic [27:0]         focal,
   output logic signed [31:0]  coord
);

   localparam int unsigned STEPS = ldr_pkg::NORM_STEPS;

   logic signed [29:0] num;
   logic               num_neg;
   logic [28:0]        mag;

   logic [27:0]        rem_ff  [0:STEPS];
   logic [STEPS-1:0]   quo_ff  [0:STEPS];
   logic               neg_ff  [0:STEPS];
   logic               sat_ff  [0:STEPS];
   logic               zero_ff [0:STEPS];
   logic               lsb_ff;
   logic signed [31:0] coord_ff;

   assign num     = $signed({2'b00, pos, 16'b0}) - $signed({2'b00, centre});
   assign num_neg = num[29];
   assign mag     = num_neg ? 29'(-num) : 29'(num);
   assign coord   = coord_ff;

   // set up magnitude, overflow and zero flags; quotient fits 31 bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= mag[28:1];
         lsb_ff     <= mag[0];
         quo_ff[0]  <= '0;
         neg_ff[0]  <= num_neg;
         sat_ff[0]  <= mag >= {focal, 1'b0};
         zero_ff[0] <= mag == 29'd0;
      end
   end

   // one quotient bit per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [28:0] trial;
      logic        ge;

      assign trial = {rem_ff[i], (i == 0) ? lsb_ff : 1'b0};
      assign ge    = trial >= {1'b0, focal};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= ge ? 28'(trial - {1'b0, focal}) : trial[27:0];
            quo_ff[i+1]  <= {quo_ff[i][STEPS-2:0], ge};
            neg_ff[i+1]  <= neg_ff[i];
            sat_ff[i+1]  <= sat_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // apply sign and clamp
   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[STEPS]) begin
            coord_ff <= '0;
         end else if (sat_ff[STEPS]) begin
            coord_ff <= neg_ff[STEPS] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else if (neg_ff[STEPS]) begin
            coord_ff <= -$signed({1'b0, quo_ff[STEPS]});
         end else begin
            coord_ff <= $signed({1'b0, quo_ff[STEPS]});
         end
      end
   end

endmodule

[rtl/ldr_distort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_distort
// Brown-Conrady radial and tangential terms, back projection and bounds
// test, as a twelve-stage pipeline alternating products and sums.
// ----------------------------------------------------------------------------
module ldr_distort #(
   parameter int unsigned        OUT_WIDTH        = ldr_pkg::DEF_OUT_WIDTH,
   parameter int unsigned        OUT_HEIGHT       = ldr_pkg::DEF_OUT_HEIGHT,
   parameter logic signed [31:0] RADIAL_THREE_Q30 = ldr_pkg::DEF_RADIAL_THREE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ldr_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  logic [7:0]          in_value,
   input  logic signed [31:0]  x,
   input  logic signed [31:0]  y,
   output logic                out_valid,
   output logic [11:0]         out_column,
   output logic [11:0]         out_row,
   output logic [7:0]          out_value,
   output logic                out_in_bounds
);

   localparam int unsigned LAT = ldr_pkg::DIST_LAT;
   localparam logic signed [31:0] LIM_X = 32'(OUT_WIDTH) <<< 16;
   localparam logic signed [31:0] LIM_Y = 32'(OUT_HEIGHT) <<< 16;

   logic             vld_ff [0:LAT-1];
   logic [7:0]       val_ff [0:LAT-1];

   logic signed [31:0] k1, k2, p1, p2;
   assign k1 = $signed(cfg.radial_one);
   assign k2 = $signed(cfg.radial_two);
   assign p1 = $signed(cfg.tangential_one);
   assign p2 = $signed(cfg.tangential_two);

   // carry valid and grey level along the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff[0] <= in_value;
         for (int i = 1; i < LAT; i++) val_ff[i] <= val_ff[i-1];
      end
   end

   // stage B: squares and cross product
   logic signed [63:0] b_pxx_ff, b_pyy_ff, b_pxy_ff;
   logic signed [31:0] b_x_ff, b_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         b_pxx_ff <= x * x;
         b_pyy_ff <= y * y;
         b_pxy_ff <= x * y;
         b_x_ff   <= x;
         b_y_ff   <= y;
      end
   end

   // stage C: r2 and tangential sums
   logic signed [31:0] c_xx, c_yy, c_r2_in;
   logic signed [31:0] c_r2_ff, c_tx_ff, c_ty_ff, c_xy_ff, c_x_ff, c_y_ff;
   assign c_xx    = ldr_pkg::qsat(b_pxx_ff);
   assign c_yy    = ldr_pkg::qsat(b_pyy_ff);
   assign c_r2_in = ldr_pkg::sat_wide(36'(c_xx) + 36'(c_yy));
   always_ff @(posedge clock) begin
      if (en) begin
         c_r2_ff <= c_r2_in;
         c_tx_ff <= ldr_pkg::sat_wide(36'(c_r2_in) + (36'(c_xx) <<< 1));
         c_ty_ff <= ldr_pkg::sat_wide(36'(c_r2_in) + (36'(c_yy) <<< 1));
         c_xy_ff <= ldr_pkg::qsat(b_pxy_ff);
         c_x_ff  <= b_x_ff;
         c_y_ff  <= b_y_ff;
      end
   end

   // stage D: r4 and coefficient products
   logic signed [63:0] d_pr4_ff, d_pk1_ff, d_p1xy_ff, d_p2tx_ff, d_p1ty_ff, d_p2xy_ff;
   logic signed [31:0] d_r2_ff, d_x_ff, d_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         d_pr4_ff  <= c_r2_ff * c_r2_ff;
         d_pk1_ff  <= k1 * c_r2_ff;
         d_p1xy_ff <= p1 * c_xy_ff;
         d_p2tx_ff <= p2 * c_tx_ff;
         d_p1ty_ff <= p1 * c_ty_ff;
         d_p2xy_ff <= p2 * c_xy_ff;
         d_r2_ff   <= c_r2_ff;
         d_x_ff    <= c_x_ff;
         d_y_ff    <= c_y_ff;
      end
   end

   // stage E: tangential offsets
   logic signed [31:0] e_r4_ff, e_a1_ff, e_dx_ff, e_dy_ff, e_r2_ff, e_x_ff, e_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         e_r4_ff <= ldr_pkg::qsat(d_pr4_ff);
         e_a1_ff <= ldr_pkg::qsat(d_pk1_ff);
         e_dx_ff <= ldr_pkg::sat_wide((36'(ldr_pkg::qsat(d_p1xy_ff)) <<< 1)
                                      + 36'(ldr_pkg::qsat(d_p2tx_ff)));
         e_dy_ff <= ldr_pkg::sat_wide(36'(ldr_pkg::qsat(d_p1ty_ff))
                                      + (36'(ldr_pkg::qsat(d_p2xy_ff)) <<< 1));
         e_r2_ff <= d_r2_ff;
         e_x_ff  <= d_x_ff;
         e_y_ff  <= d_y_ff;
      end
   end

   // stage F: r6 and k2 term
   logic signed [63:0] f_pr6_ff, f_pk2_ff;
   logic signed [31:0] f_a1_ff, f_dx_ff, f_dy_ff, f_x_ff, f_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         f_pr6_ff <= e_r4_ff * e_r2_ff;
         f_pk2_ff <= k2 * e_r4_ff;
         f_a1_ff  <= e_a1_ff;
         f_dx_ff  <= e_dx_ff;
         f_dy_ff  <= e_dy_ff;
         f_x_ff   <= e_x_ff;
         f_y_ff   <= e_y_ff;
      end
   end

   // stage G: partial radial sum, kept wide until the last term is in
   logic signed [31:0] g_r6_ff, g_dx_ff, g_dy_ff, g_x_ff, g_y_ff;
   logic signed [35:0] g_part_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         g_r6_ff   <= ldr_pkg::qsat(f_pr6_ff);
         g_part_ff <= ldr_pkg::Q30_ONE + 36'(f_a1_ff) + 36'(ldr_pkg::qsat(f_pk2_ff));
         g_dx_ff   <= f_dx_ff;
         g_dy_ff   <= f_dy_ff;
         g_x_ff    <= f_x_ff;
         g_y_ff    <= f_y_ff;
      end
   end

   // stage H: k3 term
   logic signed [63:0] h_pk3_ff;
   logic signed [35:0] h_part_ff;
   logic signed [31:0] h_dx_ff, h_dy_ff, h_x_ff, h_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         h_pk3_ff  <= RADIAL_THREE_Q30 * g_r6_ff;
         h_part_ff <= g_part_ff;
         h_dx_ff   <= g_dx_ff;
         h_dy_ff   <= g_dy_ff;
         h_x_ff    <= g_x_ff;
         h_y_ff    <= g_y_ff;
      end
   end

   // stage I: radial scale
   logic signed [31:0] i_scale_ff, i_dx_ff, i_dy_ff, i_x_ff, i_y_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         i_scale_ff <= ldr_pkg::sat_wide(h_part_ff + 36'(ldr_pkg::qsat(h_pk3_ff)));
         i_dx_ff    <= h_dx_ff;
         i_dy_ff    <= h_dy_ff;
         i_x_ff     <= h_x_ff;
         i_y_ff     <= h_y_ff;
      end
   end

   // stage J: scale the coordinates
   logic signed [63:0] j_px_ff, j_py_ff;
   logic signed [31:0] j_dx_ff, j_dy_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         j_px_ff <= i_x_ff * i_scale_ff;
         j_py_ff <= i_y_ff * i_scale_ff;
         j_dx_ff <= i_dx_ff;
         j_dy_ff <= i_dy_ff;
      end
   end

   // stage K: distorted normalized coordinates
   logic signed [31:0] k_xd_ff, k_yd_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         k_xd_ff <= ldr_pkg::sat_wide(36'(ldr_pkg::qsat(j_px_ff)) + 36'(j_dx_ff));
         k_yd_ff <= ldr_pkg::sat_wide(36'(ldr_pkg::qsat(j_py_ff)) + 36'(j_dy_ff));
      end
   end

   // stage L: back to pixel scale
   logic signed [63:0] l_pbx_ff, l_pby_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         l_pbx_ff <= k_xd_ff * $signed({4'b0, cfg.focal_x});
         l_pby_ff <= k_yd_ff * $signed({4'b0, cfg.focal_y});
      end
   end

   // stage M: add principal point, bounds test, output register
   logic signed [63:0] m_sx, m_sy;
   logic signed [31:0] m_bx, m_by;
   logic               m_ok;
   logic [11:0]        col_ff, row_ff;
   logic               ok_ff;
   assign m_sx = l_pbx_ff >>> 30;
   assign m_sy = l_pby_ff >>> 30;
   assign m_bx = m_sx[31:0] + $signed({4'b0, cfg.centre_x});
   assign m_by = m_sy[31:0] + $signed({4'b0, cfg.centre_y});
   assign m_ok = (m_bx >= 0) && (m_by >= 0) && (m_bx < LIM_X) && (m_by < LIM_Y);
   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff  <= m_ok;
         col_ff <= m_ok ? m_bx[27:16] : 12'd0;
         row_ff <= m_ok ? m_by[27:16] : 12'd0;
      end
   end

   assign out_valid     = vld_ff[LAT-1];
   assign out_value     = val_ff[LAT-1];
   assign out_column    = col_ff;
   assign out_row       = row_ff;
   assign out_in_bounds = ok_ff;

endmodule

[rtl/lens_distortion_pixel_remap.sv]
`timescale 1ns / 1ps
// Requests pass through the divider and then the distortion pipeline;
//   throughput one request per cycle while the sink does not stall.
// The whole pipeline holds while a finished response waits on a stalled sink.
// Reset clears every stage valid bit and loads the register reset values.
// ----------------------------------------------------------------------------
// lens_distortion_pixel_remap
// Brown-Conrady pixel remapper: normalize, distort, project back, bound.
// ----------------------------------------------------------------------------
module lens_distortion_pixel_remap #(
   parameter int unsigned        OUT_WIDTH        = ldr_pkg::DEF_OUT_WIDTH,
   parameter int unsigned        OUT_HEIGHT       = ldr_pkg::DEF_OUT_HEIGHT,
   parameter logic signed [31:0] RADIAL_THREE_Q30 = ldr_pkg::DEF_RADIAL_THREE
) (
   input  logic          clock,
   input  logic          reset,
   ldr_req_if.sink       req_chan,
   ldr_rsp_if.source     rsp_chan,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [4:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int unsigned NLAT = ldr_pkg::NORM_LAT;

   ldr_pkg::cfg_type   cfg;
   logic               en;
   logic               out_valid;
   logic signed [31:0] x, y;
   logic               vld_ff [0:NLAT-1];
   logic [7:0]         val_ff [0:NLAT-1];

   // advance whenever the output register is free or being taken
   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = out_valid;

   ldr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ldr_norm u_norm_x (
      .clock  (clock),
      .en     (en),
      .pos    (req_chan.src_column),
      .centre (cfg.centre_x),
      .focal  (cfg.focal_x),
      .coord  (x)
   );

   ldr_norm u_norm_y (
      .clock  (clock),
      .en     (en),
      .pos    (req_chan.src_row),
      .centre (cfg.centre_y),
      .focal  (cfg.focal_y),
      .coord  (y)
   );

   // carry valid and grey level alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NLAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < NLAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff[0] <= req_chan.pixel_value;
         for (int i = 1; i < NLAT; i++) val_ff[i] <= val_ff[i-1];
      end
   end

   ldr_distort #(
      .OUT_WIDTH        (OUT_WIDTH),
      .OUT_HEIGHT       (OUT_HEIGHT),
      .RADIAL_THREE_Q30 (RADIAL_THREE_Q30)
   ) u_distort (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .cfg           (cfg),
      .in_valid      (vld_ff[NLAT-1]),
      .in_value      (val_ff[NLAT-1]),
      .x             (x),
      .y             (y),
      .out_valid     (out_valid),
      .out_column    (rsp_chan.dest_column),
      .out_row       (rsp_chan.dest_row),
      .out_value     (rsp_chan.dest_value),
      .out_in_bounds (rsp_chan.in_bounds)
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lens distortion pixel remapper. A predictor
// of the fixed-point Brown-Conrady mapping computes each destination pixel
// for every accepted request. Responses are checked field by field and in
// order. The bench sweeps several register settings and idle patterns.
// ----------------------------------------------------------------------------

// expected destination pixels, oldest first
class remap_scoreboard;
   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  val;
      logic        ok;
   } dest_type;

   dest_type    pending[$];
   int          errors;
   int          checked;
   logic [27:0] fx, fy, cx, cy;
   longint      k1, k2, p1, p2;

   function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor shift: arithmetic right shift of a signed value
   function longint qmul(longint a, longint b);
      return sat32((a * b) >>> 30);
   endfunction

   function longint norm(logic [11:0] pos, logic [27:0] c, logic [27:0] f);
      longint num;
      num = (longint'(pos) <<< 16) - longint'(c);
      if (f == 0) return (num > 0) ? 64'sd2147483647 :
                         (num < 0) ? -64'sd2147483648 : 0;
      return sat32((num * 64'sd1073741824) / longint'(f));
   endfunction

   // note an accepted request and predict its destination
   function void note_request(logic [11:0] col, logic [11:0] row, logic [7:0] val);
      longint   x, y, xx, yy, xy, r2, r4, r6, scl, tx, ty, dx, dy, xd, yd, bx, by;
      dest_type d;
      x   = norm(col, cx, fx);
      y   = norm(row, cy, fy);
      xx  = qmul(x, x);
      yy  = qmul(y, y);
      xy  = qmul(x, y);
      r2  = sat32(xx + yy);
      r4  = qmul(r2, r2);
      r6  = qmul(r4, r2);
      scl = sat32(64'sd1073741824 + qmul(k1, r2) + qmul(k2, r4)
                  + qmul(ldr_pkg::DEF_RADIAL_THREE, r6));
      tx  = sat32(r2 + 2 * xx);
      ty  = sat32(r2 + 2 * yy);
      dx  = sat32(2 * qmul(p1, xy) + qmul(p2, tx));
      dy  = sat32(qmul(p1, ty) + 2 * qmul(p2, xy));
      xd  = sat32(qmul(x, scl) + dx);
      yd  = sat32(qmul(y, scl) + dy);
      bx  = ((xd * longint'(fx)) >>> 30) + longint'(cx);
      by  = ((yd * longint'(fy)) >>> 30) + longint'(cy);
      d.ok  = bx >= 0 && by >= 0 && bx < (64'sd1920 <<< 16) && by < (64'sd1080 <<< 16);
      d.col = d.ok ? bx[27:16] : '0;
      d.row = d.ok ? by[27:16] : '0;
      d.val = val;
      pending.push_back(d);
   endfunction

   // compare a response with the oldest prediction
   function void check_response(logic [11:0] col, logic [11:0] row, logic [7:0] val,
                                logic ok);
      dest_type d;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response col=%0d row=%0d", col, row);
         return;
      end
      d = pending.pop_front();
      if (d.col !== col || d.row !== row || d.val !== val || d.ok !== ok) begin
         errors++;
         if (errors <= 10)
            $display("mismatch exp col=%0d row=%0d val=%0d ok=%0d got %0d %0d %0d %0d",
                     d.col, d.row, d.val, d.ok, col, row, val, ok);
      end
   endfunction
endclass

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          send_idle, sink_stall, sent;

   ldr_req_if req_chan ();
   ldr_rsp_if rsp_chan ();

   remap_scoreboard sb = new();

   lens_distortion_pixel_remap i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.src_column = '0;
      req_chan.src_row = '0;
      req_chan.pixel_value = '0;
      rsp_chan.ready = 1'b0;
   end

   // check responses and randomize back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.dest_column, rsp_chan.dest_row, rsp_chan.dest_value,
                           rsp_chan.in_bounds);
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= sink_stall);
   end

   // write one register through the setup and access cycles
   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         ldr_pkg::REG_FOCAL_X:        sb.fx = data[27:0];
         ldr_pkg::REG_FOCAL_Y:        sb.fy = data[27:0];
         ldr_pkg::REG_CENTRE_X:       sb.cx = data[27:0];
         ldr_pkg::REG_CENTRE_Y:       sb.cy = data[27:0];
         ldr_pkg::REG_RADIAL_ONE:     sb.k1 = longint'($signed(data));
         ldr_pkg::REG_RADIAL_TWO:     sb.k2 = longint'($signed(data));
         ldr_pkg::REG_TANGENTIAL_ONE: sb.p1 = longint'($signed(data));
         default:                     sb.p2 = longint'($signed(data));
      endcase
   endtask

   task automatic load_config(logic [27:0] fx, logic [27:0] fy, logic [27:0] cx,
                              logic [27:0] cy, logic [31:0] k1, logic [31:0] k2,
                              logic [31:0] p1, logic [31:0] p2);
      write_reg(ldr_pkg::REG_FOCAL_X, 32'(fx));
      write_reg(ldr_pkg::REG_FOCAL_Y, 32'(fy));
      write_reg(ldr_pkg::REG_CENTRE_X, 32'(cx));
      write_reg(ldr_pkg::REG_CENTRE_Y, 32'(cy));
      write_reg(ldr_pkg::REG_RADIAL_ONE, k1);
      write_reg(ldr_pkg::REG_RADIAL_TWO, k2);
      write_reg(ldr_pkg::REG_TANGENTIAL_ONE, p1);
      write_reg(ldr_pkg::REG_TANGENTIAL_TWO, p2);
   endtask

   // present one request and hold it until accepted
   task automatic send_request(logic [11:0] col, logic [11:0] row, logic [7:0] val);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.src_column  <= col;
      req_chan.src_row     <= row;
      req_chan.pixel_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(col, row, val);
      sent++;
   endtask

   // drop valid and wait for the pipeline to drain
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_burst(int count);
      logic [11:0] col, row;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: begin col = 12'($urandom); row = 12'($urandom); end
            default: begin
               col = 12'($urandom_range(1919));
               row = 12'($urandom_range(1079));
            end
         endcase
         send_request(col, row, 8'($urandom));
      end
   endtask

   initial begin
      sb.fx = ldr_pkg::RST_FOCAL_X; sb.fy = ldr_pkg::RST_FOCAL_Y;
      sb.cx = ldr_pkg::RST_CENTRE_X; sb.cy = ldr_pkg::RST_CENTRE_Y;
      sb.k1 = longint'($signed(ldr_pkg::RST_RADIAL_ONE));
      sb.k2 = longint'($signed(ldr_pkg::RST_RADIAL_TWO));
      sb.p1 = longint'($signed(ldr_pkg::RST_TANGENTIAL_ONE));
      sb.p2 = longint'($signed(ldr_pkg::RST_TANGENTIAL_TWO));
      send_idle = 0;
      sink_stall = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, centre and value extremes with reset registers
      send_request(12'd0, 12'd0, 8'd0);
      send_request(12'd4095, 12'd4095, 8'd255);
      send_request(12'd0, 12'd4095, 8'hAA);
      send_request(12'd4095, 12'd0, 8'h55);
      send_request(12'd957, 12'd530, 8'd1);
      send_request(12'd1919, 12'd1079, 8'd128);
      send_request(12'd1920, 12'd1080, 8'd127);
      drain();

      // zero focal lengths: normalized coordinates saturate or stay zero
      load_config(28'd0, 28'd0, 28'd100 << 16, 28'd50 << 16, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(12'd100, 12'd50, 8'd9);
      send_request(12'd101, 12'd49, 8'd10);
      send_request(12'd99, 12'd51, 8'd11);
      drain();

      // coefficient extremes and tiny or huge focal lengths cause overflow
      load_config(28'd1, 28'hFFFFFFF, 28'hFFFFFFF, 28'd0, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000);
      send_request(12'd0, 12'd0, 8'd3);
      send_request(12'd4095, 12'd4095, 8'd4);
      send_request(12'd2048, 12'd1, 8'd5);
      drain();

      // random phases over several settings and idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  sink_stall = 0;  end
            1: begin send_idle = 61; sink_stall = 0;  end
            2: begin send_idle = 0;  sink_stall = 61; end
            default: begin send_idle = 28; sink_stall = 28; end
         endcase
         if (ph == 0)
            load_config(ldr_pkg::RST_FOCAL_X, ldr_pkg::RST_FOCAL_Y,
                        ldr_pkg::RST_CENTRE_X, ldr_pkg::RST_CENTRE_Y,
                        ldr_pkg::RST_RADIAL_ONE, ldr_pkg::RST_RADIAL_TWO,
                        ldr_pkg::RST_TANGENTIAL_ONE, ldr_pkg::RST_TANGENTIAL_TWO);
         else if (ph == 7)
            load_config(28'($urandom), 28'($urandom), 28'($urandom), 28'($urandom),
                        $urandom, $urandom, $urandom, $urandom);
         else
            load_config(28'($urandom_range(32'h4000000, 32'h8000000)),
                        28'($urandom_range(32'h4000000, 32'h8000000)),
                        28'($urandom_range(0, 32'h8000000)),
                        28'($urandom_range(0, 32'h5000000)),
                        $signed($urandom_range(0, 32'h8000000)) - 32'sh4000000,
                        $signed($urandom_range(0, 32'h1000000)) - 32'sh800000,
                        $signed($urandom_range(0, 32'h1000000)) - 32'sh800000,
                        $urandom);
         random_burst(215);
         drain();
      end

      $display("tb: %0d requests over 11 register settings, %0d responses checked",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end
endmodule

[files.f]
rtl/ldr_pkg.sv
rtl/ldr_req_if.sv
rtl/ldr_rsp_if.sv
rtl/ldr_csr.sv
rtl/ldr_norm.sv
rtl/ldr_distort.sv
rtl/lens_distortion_pixel_remap.sv
sim/tb.sv
